FILE: hw/rtl/rnd_pkg.sv
// Shared types, constants and the tone table for the ringtone note decoder.
// Used by every module of the block; no dependencies.
`default_nettype none
package rnd_pkg;

    localparam int DivW = 17;
    localparam int DvsW = 10;
    localparam logic [DivW-1:0] MinuteMs = 17'd60000;
    // (60000 / 63) * 2
    localparam logic [DivW-1:0] WholeReset = 17'd1904;

    localparam logic [2:0] RstOffset = 3'd0;
    localparam logic [6:0] RstLength = 7'd4;
    localparam logic [2:0] RstOctave = 3'd6;
    localparam logic [9:0] RstTempo  = 10'd63;

    localparam logic [1:0] CfgOffset = 2'd0;
    localparam logic [1:0] CfgLength = 2'd1;
    localparam logic [1:0] CfgOctave = 2'd2;
    localparam logic [1:0] CfgTempo  = 2'd3;

    localparam logic [11:0] ToneTable [0:84] = '{ 12'd0,
        12'd31, 12'd34, 12'd36, 12'd38, 12'd41, 12'd43, 12'd46, 12'd49, 12'd51, 12'd55,
        12'd58, 12'd61,
        12'd65, 12'd69, 12'd73, 12'd77, 12'd82, 12'd87, 12'd93, 12'd98, 12'd103,
        12'd110, 12'd117, 12'd123,
        12'd131, 12'd138, 12'd147, 12'd155, 12'd165, 12'd174, 12'd185, 12'd196,
        12'd207, 12'd220, 12'd233, 12'd247,
        12'd262, 12'd277, 12'd294, 12'd311, 12'd330, 12'd349, 12'd370, 12'd392,
        12'd415, 12'd440, 12'd466, 12'd494,
        12'd523, 12'd554, 12'd587, 12'd622, 12'd659, 12'd698, 12'd740, 12'd784,
        12'd831, 12'd880, 12'd932, 12'd988,
        12'd1047, 12'd1109, 12'd1175, 12'd1245, 12'd1319, 12'd1397, 12'd1480,
        12'd1568, 12'd1661, 12'd1760, 12'd1865, 12'd1976,
        12'd2093, 12'd2217, 12'd2349, 12'd2489, 12'd2637, 12'd2794, 12'd2960,
        12'd3136, 12'd3322, 12'd3520, 12'd3729, 12'd3951 };

    typedef struct packed {
        logic [7:0] symbol;
        logic       song_end;
    } in_item_t;

    typedef struct packed {
        logic [11:0] tone_hz;
        logic [17:0] duration_ms;
        logic        is_rest;
        logic        song_done;
    } out_item_t;

    typedef enum logic [3:0] {
        PH_NAME, PH_HDR_D, PH_D_EQ, PH_D_NUM, PH_HDR_O, PH_O_EQ, PH_O_DIG,
        PH_O_SKIP, PH_HDR_B, PH_B_EQ, PH_B_NUM, PH_TOKEN, PH_MODS, PH_AFTER_OCT
    } phase_t;

    typedef enum logic [2:0] {
        C_IDLE, C_LDW, C_DIVW, C_LDE, C_DIVE, C_FIN
    } ctrl_state_t;

    typedef struct packed {
        logic accept;
        logic div_start;
        logic div_whole;
        logic whole_load;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic step_emit;
        logic step_zero;
        logic step_whole;
        logic div_done;
        logic out_full;
    } dp_status_t;

endpackage
`default_nettype wire

FILE: hw/rtl/rnd_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on rnd_pkg.
`default_nettype none
module rnd_div (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic [rnd_pkg::DivW-1:0] dividend,
    input  wire logic [rnd_pkg::DvsW-1:0] divisor,
    output logic [rnd_pkg::DivW-1:0]      quotient,
    output logic                          done
);
    import rnd_pkg::*;

    logic [DivW-1:0] quo_reg, quo_next;
    logic [DvsW-1:0] rem_reg, rem_next;
    logic [DvsW-1:0] dvs_reg, dvs_next;
    logic [4:0]      cnt_reg, cnt_next;
    logic            done_reg, done_next;
    logic [DvsW:0]   rem_sh;
    logic [DvsW:0]   diff;
    logic            ge;

    always_comb
    begin
        rem_sh    = {rem_reg, quo_reg[DivW-1]};
        diff      = rem_sh - {1'b0, dvs_reg};
        ge        = rem_sh >= {1'b0, dvs_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next = dividend;
            rem_next = '0;
            dvs_next = divisor;
            cnt_next = 5'(DivW);
        end
        else if (cnt_reg != 5'd0)
        begin
            rem_next = ge ? diff[DvsW-1:0] : rem_sh[DvsW-1:0];
            quo_next = {quo_reg[DivW-2:0], ge};
            cnt_next = cnt_reg - 5'd1;
            done_next = cnt_reg == 5'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;
endmodule
`default_nettype wire

FILE: hw/rtl/rnd_ctrl.sv
// Controller: sequences character step, division and result load.
// Depends on rnd_pkg.
`default_nettype none
module rnd_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic                out_ready,
    input  wire rnd_pkg::dp_status_t status,
    output rnd_pkg::dp_cmd_t         cmd
);
    import rnd_pkg::*;

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= C_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            C_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    if (status.step_emit && status.step_zero)
                        state_next = C_FIN;
                    else if (status.step_emit)
                        state_next = C_LDE;
                    else if (status.step_whole)
                        state_next = C_LDW;
                end
            end
            C_LDW:
            begin
                cmd.div_start = 1'b1;
                cmd.div_whole = 1'b1;
                state_next    = C_DIVW;
            end
            C_DIVW:
            begin
                cmd.div_whole = 1'b1;
                if (status.div_done)
                begin
                    cmd.whole_load = 1'b1;
                    state_next     = C_IDLE;
                end
            end
            C_LDE:
            begin
                cmd.div_start = 1'b1;
                state_next    = C_DIVE;
            end
            C_DIVE:
            begin
                if (status.div_done)
                    state_next = C_FIN;
            end
            C_FIN:
            begin
                if (!status.out_full || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = C_IDLE;
                end
            end
            default:
                state_next = C_IDLE;
        endcase
    end
endmodule
`default_nettype wire

FILE: hw/rtl/rnd_datapath.sv
// Datapath: config registers, parser state, note lookup, divider and
// result register. Depends on rnd_pkg and rnd_div.
`default_nettype none
module rnd_datapath (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire rnd_pkg::in_item_t  in_data,
    input  wire logic               cfg_write,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [9:0]         cfg_data,
    input  wire logic               out_ready,
    output logic                    out_valid,
    output rnd_pkg::out_item_t      out_data,
    input  wire rnd_pkg::dp_cmd_t   cmd,
    output rnd_pkg::dp_status_t     status
);
    import rnd_pkg::*;

    function automatic logic [9:0] acc_digit(input logic [9:0] a, input logic [3:0] d,
                                             input logic [9:0] lim);
        logic [13:0] s;
        s = {4'd0, a} * 14'd10 + {10'd0, d};
        return (s > {4'd0, lim}) ? lim : s[9:0];
    endfunction

    function automatic logic [3:0] letter(input logic [7:0] c);
        case (c)
            "c":     return 4'd1;
            "d":     return 4'd3;
            "e":     return 4'd5;
            "f":     return 4'd6;
            "g":     return 4'd8;
            "a":     return 4'd10;
            "b":     return 4'd12;
            default: return 4'd0;
        endcase
    endfunction

    // config
    logic [2:0] off_reg;
    logic [6:0] rlen_reg;
    logic [2:0] roct_reg;
    logic [9:0] rtmp_reg;

    // parser state
    phase_t     phase_reg, phase_next;
    logic [9:0] num_reg, num_next;
    logic [6:0] len_reg, len_next;
    logic [2:0] oct_reg, oct_next;
    logic [9:0] tmp_reg, tmp_next;
    logic [16:0] whole_reg;
    logic [3:0] note_reg, note_next;
    logic [3:0] mods_reg, mods_next;

    // latched emission
    logic [7:0]  elen_reg;
    logic [3:0]  emods_reg;
    logic [11:0] etone_reg;
    logic        erest_reg, edone_reg, ezero_reg;

    out_item_t out_reg;
    logic      oval_reg, oval_next;

    logic [7:0] c;
    logic       is_dig;
    logic [3:0] dig;
    logic       emit, zero, done_f, need_whole, tok;
    logic [3:0] emit_oct;
    logic [2:0] rank;
    logic       rank_ok;
    logic [2:0] top1;
    logic [7:0] len_eff;
    logic signed [4:0] note_s, scale_s;
    logic [2:0] scale;
    logic [6:0] idx;
    logic [7:0] idx_raw;
    logic [11:0] tone;
    logic       rest;

    logic [DivW-1:0] dividend, quotient;
    logic [DvsW-1:0] divisor;
    logic            div_done;
    logic [17:0]     dur;

    assign c      = in_data.symbol;
    assign is_dig = c >= "0" && c <= "9";
    assign dig    = 4'(c - "0");

    always_comb
    begin
        rank_ok = 1'b1;
        case (c)
            "#":     rank = 3'd0;
            "_":     rank = 3'd1;
            ".":     rank = 3'd2;
            "*":     rank = 3'd3;
            ",":     rank = 3'd5;
            default:
            begin
                rank    = 3'd4;
                rank_ok = is_dig;
            end
        endcase
        top1 = mods_reg[3] ? 3'd4 : mods_reg[2] ? 3'd3 : mods_reg[1] ? 3'd2 :
               mods_reg[0] ? 3'd1 : 3'd0;
    end

    // note lookup for the pending note
    always_comb
    begin
        emit_oct = (!in_data.song_end && phase_reg == PH_MODS && is_dig &&
                    (rank + 3'd1) > top1) ? dig : {1'b0, oct_reg};
        len_eff = (num_reg != 10'd0) ? num_reg[7:0] : {1'b0, len_reg};
        if (len_eff == 8'd0)
            len_eff = 8'd1;
        note_s = $signed({1'b0, note_reg});
        if (mods_reg[0])
            note_s = note_s + 5'sd1;
        if (mods_reg[1])
            note_s = note_s - 5'sd1;
        scale_s = $signed({1'b0, emit_oct}) + $signed({{2{off_reg[2]}}, off_reg});
        if (scale_s < 5'sd1)
            scale = 3'd1;
        else if (scale_s > 5'sd7)
            scale = 3'd7;
        else
            scale = scale_s[2:0];
        idx_raw = 8'(({5'd0, scale} - 8'd1) * 8'd12) + {3'd0, note_s};
        idx     = (idx_raw > 8'd84) ? 7'd84 : idx_raw[6:0];
        rest    = note_s <= 5'sd0;
        tone    = rest ? 12'd0 : ToneTable[idx];
    end

    // one character step
    always_comb
    begin
        phase_next = phase_reg;
        num_next   = num_reg;
        len_next   = len_reg;
        oct_next   = oct_reg;
        tmp_next   = tmp_reg;
        note_next  = note_reg;
        mods_next  = mods_reg;
        emit       = 1'b0;
        zero       = 1'b0;
        done_f     = 1'b0;
        need_whole = 1'b0;
        tok        = 1'b0;
        if (in_data.song_end)
        begin
            emit       = 1'b1;
            done_f     = 1'b1;
            zero       = phase_reg != PH_MODS;
            phase_next = PH_NAME;
            num_next   = '0;
            note_next  = '0;
            mods_next  = '0;
        end
        else
        begin
            case (phase_reg)
                PH_NAME:
                    if (c == ":")
                    begin
                        len_next   = rlen_reg;
                        oct_next   = roct_reg;
                        tmp_next   = rtmp_reg;
                        need_whole = 1'b1;
                        phase_next = PH_HDR_D;
                    end
                PH_HDR_D, PH_HDR_O, PH_HDR_B:
                    if (phase_reg == PH_HDR_D && c == "d")
                        phase_next = PH_D_EQ;
                    else if (phase_reg != PH_HDR_B && c == "o")
                        phase_next = PH_O_EQ;
                    else if (c == "b")
                        phase_next = PH_B_EQ;
                    else
                    begin
                        need_whole = 1'b1;
                        num_next   = '0;
                        phase_next = PH_TOKEN;
                        tok        = 1'b1;
                    end
                PH_D_EQ:
                begin
                    num_next   = '0;
                    phase_next = PH_D_NUM;
                end
                PH_B_EQ:
                begin
                    num_next   = '0;
                    phase_next = PH_B_NUM;
                end
                PH_D_NUM, PH_B_NUM:
                    if (is_dig)
                        num_next = acc_digit(num_reg, dig, 10'd1023);
                    else
                    begin
                        if (phase_reg == PH_D_NUM)
                        begin
                            if (num_reg != 10'd0)
                                len_next = (num_reg > 10'd127) ? 7'd127 : num_reg[6:0];
                            phase_next = PH_HDR_O;
                        end
                        else
                        begin
                            if (num_reg != 10'd0)
                                tmp_next = num_reg;
                            need_whole = 1'b1;
                            phase_next = PH_TOKEN;
                        end
                        num_next = '0;
                    end
                PH_O_EQ:
                    phase_next = PH_O_DIG;
                PH_O_DIG:
                begin
                    if (c >= "1" && c <= "7")
                        oct_next = dig[2:0];
                    phase_next = PH_O_SKIP;
                end
                PH_O_SKIP:
                    phase_next = PH_HDR_B;
                PH_TOKEN:
                    tok = 1'b1;
                PH_AFTER_OCT:
                begin
                    phase_next = PH_TOKEN;
                    tok        = c != ",";
                end
                PH_MODS:
                    if (rank_ok && (rank + 3'd1) > top1 && rank < 3'd4)
                        mods_next = mods_reg | (4'd1 << rank[1:0]);
                    else
                    begin
                        emit       = 1'b1;
                        num_next   = '0;
                        note_next  = '0;
                        mods_next  = '0;
                        phase_next = PH_TOKEN;
                        if (rank_ok && (rank + 3'd1) > top1)
                        begin
                            if (rank == 3'd4)
                                phase_next = PH_AFTER_OCT;
                        end
                        else
                            tok = 1'b1;
                    end
                default:
                    phase_next = PH_NAME;
            endcase
            if (tok)
            begin
                if (is_dig)
                    num_next = acc_digit(num_next, dig, 10'd255);
                else
                begin
                    note_next  = letter(c);
                    mods_next  = '0;
                    phase_next = PH_MODS;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_reg   <= RstOffset;
            rlen_reg  <= RstLength;
            roct_reg  <= RstOctave;
            rtmp_reg  <= RstTempo;
            phase_reg <= PH_NAME;
            num_reg   <= '0;
            len_reg   <= RstLength;
            oct_reg   <= RstOctave;
            tmp_reg   <= RstTempo;
            whole_reg <= WholeReset;
            note_reg  <= '0;
            mods_reg  <= '0;
            oval_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CfgOffset: off_reg  <= cfg_data[2:0];
                    CfgLength: rlen_reg <= cfg_data[6:0];
                    CfgOctave: roct_reg <= cfg_data[2:0];
                    CfgTempo:  rtmp_reg <= cfg_data;
                    default:   rtmp_reg <= rtmp_reg;
                endcase
            end
            if (cmd.accept)
            begin
                phase_reg <= phase_next;
                num_reg   <= num_next;
                len_reg   <= len_next;
                oct_reg   <= oct_next;
                tmp_reg   <= tmp_next;
                note_reg  <= note_next;
                mods_reg  <= mods_next;
            end
            if (cmd.whole_load)
                whole_reg <= {quotient[DivW-2:0], 1'b0};
            oval_reg <= oval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            elen_reg  <= len_eff;
            emods_reg <= mods_reg;
            etone_reg <= zero ? 12'd0 : tone;
            erest_reg <= zero ? 1'b0 : rest;
            edone_reg <= done_f;
            ezero_reg <= zero;
        end
        if (cmd.out_load)
        begin
            out_reg.tone_hz     <= etone_reg;
            out_reg.duration_ms <= ezero_reg ? 18'd0 : dur;
            out_reg.is_rest     <= erest_reg;
            out_reg.song_done   <= edone_reg;
        end
    end

    assign oval_next = cmd.out_load | (oval_reg & ~out_ready);

    always_comb
    begin
        if (cmd.div_whole)
        begin
            dividend = MinuteMs;
            divisor  = (tmp_reg == 10'd0) ? 10'd1 : tmp_reg;
        end
        else
        begin
            dividend = whole_reg;
            divisor  = {2'd0, elen_reg};
        end
    end

    rnd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .quotient (quotient),
        .done     (div_done)
    );

    // dotted adds half, star adds an eighth of a whole note
    assign dur = {1'b0, quotient}
               + (emods_reg[2] ? {2'd0, quotient[DivW-1:1]} : 18'd0)
               + (emods_reg[3] ? {4'd0, whole_reg[16:3]} : 18'd0);

    assign status.step_emit  = emit;
    assign status.step_zero  = zero;
    assign status.step_whole = need_whole;
    assign status.div_done   = div_done;
    assign status.out_full   = oval_reg;

    assign out_valid = oval_reg;
    assign out_data  = out_reg;
endmodule
`default_nettype wire

FILE: hw/rtl/rtttl_note_decoder_core.sv
// Top level of the ringtone note decoder: controller plus datapath.
// Depends on rnd_pkg, rnd_ctrl, rnd_datapath, rnd_div.
//
// Takes one song character per request and gives at most one note result
// per character. A character that only moves the parser needs no division;
// one that sets the tempo or ends a song name runs the shared bit-serial
// divider for the whole note from the tempo, and one that finishes a note
// runs it for the duration from the length. Characters are handled one at
// a time; a finished result waits in the output register while the next
// character is taken. Length, octave and tempo writes take effect at the
// next ':' ending a song name; an offset write applies to the next note.
`default_nettype none
module rtttl_note_decoder_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire rnd_pkg::in_item_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output rnd_pkg::out_item_t      out_data,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [9:0]         cfg_data
);
    import rnd_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    rnd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    rnd_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_write (cfg_valid & cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data),
        .cmd       (cmd),
        .status    (status)
    );

    // a stalled result holds still
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    a_rest_silent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.is_rest |-> out_data.tone_hz == 12'd0)
        else $error("rest with a tone");

    a_dur_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.duration_ms <= 18'd195000)
        else $error("duration out of range");
endmodule
`default_nettype wire
